/* hw/rtl/rncv_pkg.sv */
package rncv_pkg;

  // Digit store depth and the saturating character count
  localparam int unsigned StoreDepth = 12;
  localparam logic [3:0]  PosSat     = 4'd13;

  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  typedef logic [3:0] pos_t;
  typedef logic [StoreDepth-1:0][3:0] digits_t;

  // Number kind held in the configuration register
  typedef enum logic {
    KIND_TAX = 1'b0,
    KIND_CLS = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_CHECKED = 2'd0,
    ST_BAD_LEN = 2'd1,
    ST_BAD_SYM = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_item_t;

  typedef struct packed {
    status_e status;
    logic    check_ok;
  } out_item_t;

  // Finished number waiting for evaluation
  typedef struct packed {
    pos_t  len;
    logic  bad;
    kind_e kind;
  } snap_t;

  // Weight tables, entry 0 is the leftmost digit (listed from entry 11 down)
  localparam digits_t WTax10 = {4'd0, 4'd0, 4'd0, 4'd8, 4'd6, 4'd4,
                                4'd9, 4'd5, 4'd3, 4'd10, 4'd4, 4'd2};
  localparam digits_t WTax12a = {4'd0, 4'd0, 4'd8, 4'd6, 4'd4, 4'd9,
                                 4'd5, 4'd3, 4'd10, 4'd4, 4'd2, 4'd7};
  localparam digits_t WTax12b = {4'd0, 4'd8, 4'd6, 4'd4, 4'd9, 4'd5,
                                 4'd3, 4'd10, 4'd4, 4'd2, 4'd7, 4'd3};
  localparam digits_t WCls1 = {4'd2, 4'd1, 4'd10, 4'd9, 4'd8, 4'd7,
                               4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1};
  localparam digits_t WCls2 = {4'd4, 4'd3, 4'd2, 4'd1, 4'd10, 4'd9,
                               4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3};

endpackage

/* hw/rtl/rncv_accum.sv */
module rncv_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  rncv_pkg::in_item_t in_data_i,
  input  rncv_pkg::kind_e   kind_i,
  input  logic              snap_take_i,
  output rncv_pkg::digits_t digits_o,
  output logic              snap_valid_o,
  output rncv_pkg::snap_t   snap_o
);
  import rncv_pkg::*;

  logic    [3:0] store_q [StoreDepth];
  pos_t          pos_q, pos_d;
  logic          bad_q, bad_d;
  logic          snap_valid_q;
  snap_t         snap_q;
  logic          is_digit;
  logic    [3:0] digit_val;
  logic    [7:0] char_off;

  // Character decode
  assign is_digit  = (in_data_i.char_code >= CharZero) && (in_data_i.char_code <= CharNine);
  assign char_off  = in_data_i.char_code - CharZero;
  assign digit_val = is_digit ? char_off[3:0] : 4'd0;

  assign pos_d = (pos_q < PosSat) ? pos_q + 4'd1 : pos_q;
  assign bad_d = bad_q | ~is_digit;

  // Digit store, written at the current position
  always_ff @(posedge clk_i) begin
    if (fire_i && (pos_q < 4'(StoreDepth))) begin
      store_q[pos_q] <= digit_val;
    end
  end

  // Position, symbol flag and hand-off of a finished number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      bad_q        <= 1'b0;
      snap_valid_q <= 1'b0;
    end else if (fire_i && in_data_i.last) begin
      pos_q        <= '0;
      bad_q        <= 1'b0;
      snap_valid_q <= 1'b1;
    end else begin
      if (fire_i) begin
        pos_q <= pos_d;
        bad_q <= bad_d;
      end
      if (snap_take_i) begin
        snap_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && in_data_i.last) begin
      snap_q <= '{len: pos_d, bad: bad_d, kind: kind_i};
    end
  end

  always_comb begin
    for (int i = 0; i < StoreDepth; i++) begin
      digits_o[i] = store_q[i];
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

/* hw/rtl/rncv_check.sv */
module rncv_check (
  input  rncv_pkg::digits_t   digits_i,
  input  rncv_pkg::snap_t     snap_i,
  output rncv_pkg::out_item_t result_o
);
  import rncv_pkg::*;

  // Remainder mod 11 for sums below 2048: reciprocal estimate, one correction
  function automatic logic [3:0] mod11(input logic [10:0] s);
    logic [19:0] prod;
    logic [10:0] qm;
    logic [4:0]  r;
    prod = 20'(s) * 20'd372;
    qm   = 11'(prod[19:12]) * 11'd11;
    r    = 5'(s - qm);
    if (r >= 5'd11) begin
      r = r - 5'd11;
    end
    return r[3:0];
  endfunction

  function automatic logic [3:0] fold10(input logic [3:0] r);
    return (r == 4'd10) ? 4'd0 : r;
  endfunction

  logic [10:0] s_t10, s_t12a, s_t12b, s_c1, s_c2;
  logic [3:0]  n_cls, r_c1, r_c2, cls_rest, cls_digit;
  logic        len_ok, tax_ok, cls_ok;

  // Weighted sums over the stored digits; each sum covers only its own positions
  always_comb begin
    s_t10  = '0;
    s_t12a = '0;
    s_t12b = '0;
    s_c1   = '0;
    s_c2   = '0;
    n_cls  = snap_i.len - 4'd1;
    for (int i = 0; i < StoreDepth; i++) begin
      if (i < 9) begin
        s_t10 = s_t10 + 11'(digits_i[i]) * 11'(WTax10[i]);
      end
      if (i < 10) begin
        s_t12a = s_t12a + 11'(digits_i[i]) * 11'(WTax12a[i]);
      end
      if (i < 11) begin
        s_t12b = s_t12b + 11'(digits_i[i]) * 11'(WTax12b[i]);
      end
      if (4'(i) < n_cls) begin
        s_c1 = s_c1 + 11'(digits_i[i]) * 11'(WCls1[i]);
        s_c2 = s_c2 + 11'(digits_i[i]) * 11'(WCls2[i]);
      end
    end
  end

  // Classifier: second pass when the first remainder is ten
  assign r_c1     = mod11(s_c1);
  assign r_c2     = mod11(s_c2);
  assign cls_rest = (r_c1 == 4'd10) ? fold10(r_c2) : r_c1;
  assign cls_digit = (snap_i.len == 4'd8) ? digits_i[7] : digits_i[9];
  assign cls_ok   = (cls_digit == cls_rest);

  // Taxpayer: one or two check digits
  always_comb begin
    if (snap_i.len == 4'd10) begin
      tax_ok = (digits_i[9] == fold10(mod11(s_t10)));
    end else begin
      tax_ok = (digits_i[10] == fold10(mod11(s_t12a)))
            && (digits_i[11] == fold10(mod11(s_t12b)));
    end
  end

  // Length rule per kind
  always_comb begin
    unique case (snap_i.kind)
      KIND_TAX: len_ok = (snap_i.len == 4'd10) || (snap_i.len == 4'd12);
      KIND_CLS: len_ok = (snap_i.len == 4'd8) || (snap_i.len == 4'd10);
      default:  len_ok = 1'b0;
    endcase
  end

  // Status priority: length, then symbol
  always_comb begin
    result_o.check_ok = 1'b0;
    if (!len_ok) begin
      result_o.status = ST_BAD_LEN;
    end else if (snap_i.bad) begin
      result_o.status = ST_BAD_SYM;
    end else begin
      result_o.status   = ST_CHECKED;
      result_o.check_ok = (snap_i.kind == KIND_TAX) ? tax_ok : cls_ok;
    end
  end

endmodule

/* hw/rtl/registry_number_check_digit_validator.sv */
// Takes one character per cycle unless a finished number waits on a stalled result.
// After the last character of a number is accepted, the number is held in the
// finished-number register, then evaluated into the result register.
// Asynchronous active-low reset clears the count, flags, valids and kind (taxpayer).
// The digit store is not reset.
module registry_number_check_digit_validator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rncv_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rncv_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);
  import rncv_pkg::*;

  kind_e     kind_q;
  digits_t   digits;
  logic      snap_valid;
  snap_t     snap;
  out_item_t result;
  out_item_t out_q;
  logic      out_valid_q;
  logic      res_load;
  logic      in_fire;

  // Handshake: result register frees when empty or taken
  assign res_load    = ~out_valid_q | out_ready_i;
  assign in_ready_o  = ~snap_valid | res_load;
  assign in_fire     = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_TAX;
    end else if (cfg_valid_i) begin
      kind_q <= kind_e'(cfg_data_i);
    end
  end

  rncv_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .in_data_i   (in_data_i),
    .kind_i      (kind_q),
    .snap_take_i (res_load),
    .digits_o    (digits),
    .snap_valid_o(snap_valid),
    .snap_o      (snap)
  );

  rncv_check u_check (
    .digits_i(digits),
    .snap_i  (snap),
    .result_o(result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= snap_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load && snap_valid) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* verif/rncv_checker.sv */
package rncv_check_pkg;
  import rncv_pkg::*;

  // Taxpayer weights for the longest sum; shorter sums use a tail of this list
  localparam logic [10:0][3:0] TaxWeights = {4'd8, 4'd6, 4'd4, 4'd9, 4'd5, 4'd3,
                                             4'd10, 4'd4, 4'd2, 4'd7, 4'd3};

  // Check value for the digit at index n, computed from digits 0..n-1
  function automatic logic [3:0] check_digit(kind_e kind, digits_t d, int n);
    int acc;
    int rest;
    int i;
    acc = 0;
    if (kind == KIND_TAX) begin
      for (i = 0; i < n; i++) acc += int'(d[i]) * int'(TaxWeights[i + 11 - n]);
      return 4'((acc % 11) % 10);
    end
    for (i = 0; i < n; i++) acc += int'(d[i]) * ((i % 10) + 1);
    rest = acc % 11;
    // remainder of ten: second pass with weights shifted by two
    if (rest == 10) begin
      acc = 0;
      for (i = 0; i < n; i++) acc += int'(d[i]) * (((i + 2) % 10) + 1);
      rest = acc % 11;
      if (rest == 10) rest = 0;
    end
    return 4'(rest);
  endfunction
endpackage

module rncv_checker
  import rncv_pkg::*;
  import rncv_check_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic      cfg_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  kind_e      cur_kind;
  pos_t       char_count;
  digits_t    digit_val;
  logic       saw_bad;
  logic       is_digit;
  out_item_t  want;
  out_item_t  expected_results[$];

  // Status and check flag for the number that just ended
  function automatic out_item_t grade_number();
    out_item_t r;
    logic      len_ok;
    r.check_ok = 1'b0;
    if (cur_kind == KIND_TAX) len_ok = (char_count == 10) || (char_count == 12);
    else len_ok = (char_count == 8) || (char_count == 10);
    if (!len_ok) begin
      r.status = ST_BAD_LEN;
    end else if (saw_bad) begin
      r.status = ST_BAD_SYM;
    end else begin
      r.status = ST_CHECKED;
      if (cur_kind == KIND_TAX && char_count == 10) begin
        r.check_ok = (digit_val[9] == check_digit(KIND_TAX, digit_val, 9));
      end else if (cur_kind == KIND_TAX) begin
        r.check_ok = (digit_val[10] == check_digit(KIND_TAX, digit_val, 10)) &&
                     (digit_val[11] == check_digit(KIND_TAX, digit_val, 11));
      end else begin
        r.check_ok = (digit_val[char_count - 1] ==
                      check_digit(KIND_CLS, digit_val, int'(char_count) - 1));
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_kind   = KIND_TAX;
      char_count = '0;
      saw_bad    = 1'b0;
      digit_val  = '0;
      expected_results.delete();
      pending_o  = 0;
    end else begin
      // register write
      if (cfg_valid_i && cfg_ready_i) cur_kind = kind_e'(cfg_data_i);

      // result transfer: compare with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected result: status %0d check_ok %0b",
                     out_data_i.status, out_data_i.check_ok);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (want.status !== out_data_i.status || want.check_ok !== out_data_i.check_ok) begin
            if (fail_count_o < 10)
              $display("mismatch: expected status %0d check_ok %0b, got status %0d check_ok %0b",
                       want.status, want.check_ok, out_data_i.status, out_data_i.check_ok);
            fail_count_o++;
          end
        end
      end

      // character transfer: update count, digits and bad-symbol flag
      if (in_valid_i && in_ready_i) begin
        is_digit = (in_data_i.char_code >= CharZero) && (in_data_i.char_code <= CharNine);
        if (char_count < StoreDepth)
          digit_val[char_count] = is_digit ? 4'(in_data_i.char_code - CharZero) : 4'd0;
        if (!is_digit) saw_bad = 1'b1;
        if (char_count < PosSat) char_count = char_count + 4'd1;
        if (in_data_i.last) begin
          expected_results.push_back(grade_number());
          char_count = '0;
          saw_bad    = 1'b0;
        end
      end

      pending_o = expected_results.size();
    end
  end

endmodule

/* verif/tb.sv */
module tb;
  import rncv_pkg::*;
  import rncv_check_pkg::*;

  localparam int IdleLimit   = 1000;
  localparam int PhaseItems  = 220;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_data_i;
  int        fail_count;
  int        pending;

  kind_e     cur_kind;
  int        idle_pct;
  int        stall_pct;
  int        items_sent;
  int        idle_cycles;

  registry_number_check_digit_validator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  rncv_checker i_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result-side backpressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog: cycles without any transfer
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // One character; valid stays high after the transfer until the next call
  task automatic send_char(input logic [7:0] code, input logic is_last);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {code, is_last};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_char(s[k], k == s.len() - 1);
  endtask

  // Register write once all results are in and the pipeline has drained
  task automatic set_kind(input kind_e kind);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= kind;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_kind = kind;
  endtask

  // Mostly well-formed numbers, some with a stray symbol, the rest noise
  task automatic send_random_number();
    digits_t          d;
    logic [15:0][7:0] codes;
    logic [7:0]       junk;
    int               len;
    int               pick;
    int               k;
    pick  = $urandom_range(99);
    d     = '0;
    codes = '0;
    if (pick < 75) begin
      if (cur_kind == KIND_TAX) len = $urandom_range(1) ? 12 : 10;
      else len = $urandom_range(1) ? 10 : 8;
      for (k = 0; k < len; k++) d[k] = 4'($urandom_range(9));
      if (pick < 55) begin
        if (cur_kind == KIND_TAX && len == 12) d[10] = check_digit(cur_kind, d, 10);
        d[len - 1] = check_digit(cur_kind, d, len - 1);
      end
      for (k = 0; k < len; k++) codes[k] = CharZero + 8'(d[k]);
      if (pick >= 68) begin
        do junk = 8'($urandom_range(255)); while (junk >= CharZero && junk <= CharNine);
        codes[$urandom_range(len - 1)] = junk;
      end
    end else begin
      len = $urandom_range(16, 1);
      for (k = 0; k < len; k++) begin
        if ($urandom_range(9) < 7) codes[k] = CharZero + 8'($urandom_range(9));
        else codes[k] = 8'($urandom_range(255));
      end
    end
    for (k = 0; k < len; k++) send_char(codes[k], k == len - 1);
    items_sent += len;
  endtask

  initial begin
    int ph;
    int phase_start;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    cur_kind    = KIND_TAX;
    idle_pct    = 0;
    stall_pct   = 0;
    items_sent  = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: one-character numbers with extreme codes (length beats symbol)
    set_kind(KIND_TAX);
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    // classifier: both passes give ten, so the check digit is zero
    set_kind(KIND_CLS);
    send_text("20000090");
    // symbols just outside the digit range
    send_text("/234567:");

    // Random phases: alternate kinds, step through the idling patterns
    for (ph = 0; ph < 8; ph++) begin
      set_kind(kind_e'(ph[0]));
      case (ph >> 1)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) send_random_number();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
